### design/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg: shared codes for the positional insert/delete array
// Request codes, status codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pia_pkg;

    localparam int DataW      = 32;
    localparam int ReqW       = 3;
    localparam int PosW       = 5;
    localparam int StatusW    = 2;
    localparam int CountW     = 6;
    localparam int MaxResults = 32;

    localparam logic [ReqW-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [ReqW-1:0] REQ_APPEND = 3'd1;
    localparam logic [ReqW-1:0] REQ_INSERT = 3'd2;
    localparam logic [ReqW-1:0] REQ_DELETE = 3'd3;
    localparam logic [ReqW-1:0] REQ_DUMP   = 3'd4;

    localparam logic [StatusW-1:0] ST_OK     = 2'd0;
    localparam logic [StatusW-1:0] ST_BADPOS = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL   = 2'd2;
    localparam logic [StatusW-1:0] ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

### design/pia_ram.sv
// ----------------------------------------------------------------------------
// pia_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array: ordered array with positional edits
// Holds up to DEPTH signed words and a count. Serves clear, append, insert
// at position, delete at position and dump, one request at a time.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+-----------
//  request | in        | s_req_type, s_position, s_value              | s_valid/s_ready
//  result  | out       | m_status, m_data, m_count, m_last            | m_valid/m_ready
//
//  Insert below the end moves the words from the position up by one, top first,
//  then writes the value; delete returns the removed word and moves the words
//  above it down; dump sends the words from index 0, at most 32 words. The single
//  read port of the element RAM moves one word per cycle unless a result stall
//  holds a dump. s_ready is high only in the idle state. A stalled result holds
//  the sequencer; a dump resumes with the word it was about to send.
//  aresetn (synchronous, active low) clears the count and the control state;
//  the element RAM is not cleared and only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_array #(
    parameter int DEPTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic        [pia_pkg::ReqW-1:0]     s_req_type,
    input  wire logic        [pia_pkg::PosW-1:0]     s_position,
    input  wire logic signed [pia_pkg::DataW-1:0]    s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic             [pia_pkg::StatusW-1:0]  m_status,
    output logic signed      [pia_pkg::DataW-1:0]    m_data,
    output logic             [pia_pkg::CountW-1:0]   m_count,
    output logic                                     m_last
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = CW + pia_pkg::PosW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_FIRST,
        S_DEL_CAP,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESP
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [CW-1:0]                   dump_end_reg, dump_end_next;
    logic [pia_pkg::ReqW-1:0]        req_reg, req_next;
    logic [pia_pkg::PosW-1:0]        pos_reg, pos_next;
    logic [pia_pkg::DataW-1:0]       val_reg, val_next;
    logic [pia_pkg::StatusW-1:0]     status_reg, status_next;
    logic [pia_pkg::DataW-1:0]       data_reg, data_next;

    logic                            m_valid_reg, m_valid_next;
    logic [pia_pkg::StatusW-1:0]     m_status_reg, m_status_next;
    logic [pia_pkg::DataW-1:0]       m_data_reg, m_data_next;
    logic [pia_pkg::CountW-1:0]      m_count_reg, m_count_next;
    logic                            m_last_reg, m_last_next;

    // element RAM ports
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [pia_pkg::DataW-1:0]       wr_data;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [pia_pkg::DataW-1:0]       rd_data;

    logic [CW-1:0]                   idx_m1, idx_m2, idx_p1, idx_p2;
    logic [CMPW-1:0]                 pos_ext, cnt_ext;
    logic                            full;
    logic                            out_free;

    pia_ram #(
        .WIDTH (pia_pkg::DataW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_m1   = idx_reg - CW'(1);
    assign idx_m2   = idx_reg - CW'(2);
    assign idx_p1   = idx_reg + CW'(1);
    assign idx_p2   = idx_reg + CW'(2);
    assign pos_ext  = CMPW'(pos_reg);
    assign cnt_ext  = CMPW'(count_reg);
    assign full     = (count_reg == CW'(DEPTH));
    // the result register can take a word this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        dump_end_next = dump_end_reg;
        req_next      = req_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        data_next     = data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg[AW-1:0];
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                // latch the request word
                if (s_valid) begin
                    req_next   = s_req_type;
                    pos_next   = s_position;
                    val_next   = s_value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                status_next = pia_pkg::ST_OK;
                data_next   = '0;
                state_next  = S_RESP;
                case (req_reg)
                    pia_pkg::REQ_CLEAR: begin
                        count_next = '0;
                    end
                    pia_pkg::REQ_APPEND: begin
                        if (full) begin
                            status_next = pia_pkg::ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    pia_pkg::REQ_INSERT: begin
                        if (pos_ext > cnt_ext) begin
                            status_next = pia_pkg::ST_BADPOS;
                        end else if (full) begin
                            status_next = pia_pkg::ST_FULL;
                        end else if (pos_ext == cnt_ext) begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = val_reg;
                            count_next = count_reg + CW'(1);
                        end else begin
                            // open a gap: move words up from the top end
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    pia_pkg::REQ_DELETE: begin
                        if (pos_ext >= cnt_ext) begin
                            status_next = pia_pkg::ST_BADPOS;
                        end else begin
                            idx_next   = CW'(pos_reg);
                            state_next = S_DEL_FIRST;
                        end
                    end
                    pia_pkg::REQ_DUMP: begin
                        if (count_reg == '0) begin
                            status_next = pia_pkg::ST_EMPTY;
                        end else begin
                            idx_next = '0;
                            // cap the dump at the result limit
                            if (cnt_ext > CMPW'(pia_pkg::MaxResults)) begin
                                dump_end_next = CW'(pia_pkg::MaxResults - 1);
                            end else begin
                                dump_end_next = count_reg - CW'(1);
                            end
                            state_next = S_DUMP_RD;
                        end
                    end
                    default: begin
                        // unknown code: report the count, change nothing
                    end
                endcase
            end

            S_INS_RD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_m1[AW-1:0];
                state_next = S_INS_WR;
            end

            S_INS_WR: begin
                // write the word read last cycle one place up, fetch the next
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_data  = rd_data;
                idx_next = idx_m1;
                if (CMPW'(idx_m1) > pos_ext) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_m2[AW-1:0];
                end else begin
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = AW'(pos_reg);
                wr_data    = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end

            S_DEL_FIRST: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg[AW-1:0];
                state_next = S_DEL_CAP;
            end

            S_DEL_CAP: begin
                // keep the removed word, then close the gap from below
                data_next = rd_data;
                if (idx_p1 < count_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_p1[AW-1:0];
                    state_next = S_DEL_WR;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_DEL_WR: begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_data  = rd_data;
                idx_next = idx_p1;
                if (idx_p2 < count_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_p2[AW-1:0];
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_DUMP_RD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg[AW-1:0];
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT: begin
                // read data holds while the result side stalls
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pia_pkg::ST_OK;
                    m_data_next   = rd_data;
                    m_count_next  = pia_pkg::CountW'(count_reg);
                    m_last_next   = (idx_reg == dump_end_reg);
                    if (idx_reg == dump_end_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_p1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_p1[AW-1:0];
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_data_next   = data_reg;
                    m_count_next  = pia_pkg::CountW'(count_reg);
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        dump_end_reg <= dump_end_next;
        req_reg      <= req_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_count  = m_count_reg;
    assign m_last   = m_last_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in work");

    a_multi_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status == pia_pkg::ST_OK))
        else $error("non-final word with a failing status");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_PUT) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the count");
`endif

endmodule

`default_nettype wire

### dv/tb_positional_insert_delete_array.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_insert_delete_array: self-checking bench for the array block
// Feeds clear, append, insert, delete, dump and unused request codes through
// the request channel, predicts every result word from a mirror of the array
// and checks each result word in order, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_positional_insert_delete_array;

    localparam int Depth = 32;
    // highest code the request field can carry; codes above REQ_DUMP are unused
    localparam logic [pia_pkg::ReqW-1:0] REQ_CODE_TOP = {pia_pkg::ReqW{1'b1}};

    typedef struct {
        logic [pia_pkg::ReqW-1:0]         req;
        logic [pia_pkg::PosW-1:0]         pos;
        logic signed [pia_pkg::DataW-1:0] val;
    } request_t;

    typedef struct {
        logic [pia_pkg::StatusW-1:0]      status;
        logic signed [pia_pkg::DataW-1:0] data;
        logic [pia_pkg::CountW-1:0]       count;
        logic                             last;
    } result_t;

    logic                             aclk       = 1'b0;
    logic                             aresetn    = 1'b0;
    logic                             s_valid    = 1'b0;
    logic                             s_ready;
    logic [pia_pkg::ReqW-1:0]         s_req_type = '0;
    logic [pia_pkg::PosW-1:0]         s_position = '0;
    logic signed [pia_pkg::DataW-1:0] s_value    = '0;
    logic                             m_valid;
    logic                             m_ready    = 1'b0;
    logic [pia_pkg::StatusW-1:0]      m_status;
    logic signed [pia_pkg::DataW-1:0] m_data;
    logic [pia_pkg::CountW-1:0]       m_count;
    logic                             m_last;

    // words waiting to be driven, and result words the array still owes us
    request_t                         pending_requests[$];
    result_t                          results_due[$];

    // mirror of the array contents as of the last accepted request
    logic signed [pia_pkg::DataW-1:0] element_mirror[Depth];
    logic [pia_pkg::CountW-1:0]       mirror_count = '0;

    // fill level as planned by the stimulus, ahead of the driver
    int                               plan_fill     = 0;
    int                               planned_items = 0;

    int                               send_idle_pct  = 0;
    int                               recv_stall_pct = 0;
    int                               fail_count     = 0;

    positional_insert_delete_array #(
        .DEPTH(Depth)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req_type(s_req_type),
        .s_position(s_position),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_data    (m_data),
        .m_count   (m_count),
        .m_last    (m_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // hold reset at the start, then release it for good
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // record one result word; count always reports the level after the request
    function automatic void owe_result(logic [pia_pkg::StatusW-1:0] st,
                                       logic signed [pia_pkg::DataW-1:0] d,
                                       logic lst);
        result_t r;
        r.status = st;
        r.data   = d;
        r.count  = mirror_count;
        r.last   = lst;
        results_due.push_back(r);
    endfunction

    // apply one accepted request to the mirror and queue the words it causes
    function automatic void apply_request(request_t rq);
        int j;
        int n;
        case (rq.req)
            pia_pkg::REQ_CLEAR: begin
                mirror_count = '0;
                owe_result(pia_pkg::ST_OK, '0, 1'b1);
            end
            pia_pkg::REQ_APPEND: begin
                if (mirror_count >= Depth) begin
                    owe_result(pia_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    element_mirror[mirror_count] = rq.val;
                    mirror_count++;
                    owe_result(pia_pkg::ST_OK, '0, 1'b1);
                end
            end
            pia_pkg::REQ_INSERT: begin
                // position check wins over the full check
                if (rq.pos > mirror_count) begin
                    owe_result(pia_pkg::ST_BADPOS, '0, 1'b1);
                end else if (mirror_count >= Depth) begin
                    owe_result(pia_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    for (j = mirror_count; j > rq.pos; j--)
                        element_mirror[j] = element_mirror[j-1];
                    element_mirror[rq.pos] = rq.val;
                    mirror_count++;
                    owe_result(pia_pkg::ST_OK, '0, 1'b1);
                end
            end
            pia_pkg::REQ_DELETE: begin
                if (rq.pos >= mirror_count) begin
                    owe_result(pia_pkg::ST_BADPOS, '0, 1'b1);
                end else begin
                    n = element_mirror[rq.pos];
                    for (j = rq.pos; j + 1 < mirror_count; j++)
                        element_mirror[j] = element_mirror[j+1];
                    mirror_count--;
                    owe_result(pia_pkg::ST_OK, n, 1'b1);
                end
            end
            pia_pkg::REQ_DUMP: begin
                if (mirror_count == 0) begin
                    owe_result(pia_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    n = (mirror_count > pia_pkg::MaxResults) ? pia_pkg::MaxResults
                                                              : mirror_count;
                    for (j = 0; j < n; j++)
                        owe_result(pia_pkg::ST_OK, element_mirror[j], j == n - 1);
                end
            end
            default: begin
                // unused codes leave the array alone
                owe_result(pia_pkg::ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // add a word to the send queue and track the fill level it will leave
    function automatic void queue_request(logic [pia_pkg::ReqW-1:0] req, int pos,
                                          logic signed [pia_pkg::DataW-1:0] val);
        request_t rq;
        rq.req = req;
        rq.pos = pos[pia_pkg::PosW-1:0];
        rq.val = val;
        pending_requests.push_back(rq);
        case (req)
            pia_pkg::REQ_CLEAR:  plan_fill = 0;
            pia_pkg::REQ_APPEND: if (plan_fill < Depth) plan_fill++;
            pia_pkg::REQ_INSERT: if (rq.pos <= plan_fill && plan_fill < Depth) plan_fill++;
            pia_pkg::REQ_DELETE: if (rq.pos < plan_fill) plan_fill--;
            default: ;
        endcase
        planned_items++;
    endfunction

    // mostly random words, with the sign/zero extremes mixed in
    function automatic logic signed [pia_pkg::DataW-1:0] random_value();
        case ($urandom_range(15))
            0:       return {1'b0, {(pia_pkg::DataW-1){1'b1}}};
            1:       return {1'b1, {(pia_pkg::DataW-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // fill the array, hit it while full, dump it and trim the top word
    function automatic void fill_to_full();
        while (plan_fill < Depth) begin
            if ($urandom_range(1))
                queue_request(pia_pkg::REQ_APPEND, $urandom_range(31), random_value());
            else
                queue_request(pia_pkg::REQ_INSERT,
                              $urandom_range(plan_fill > 31 ? 31 : plan_fill, 0),
                              random_value());
        end
        queue_request(pia_pkg::REQ_APPEND, $urandom_range(31), random_value());
        queue_request(pia_pkg::REQ_INSERT, $urandom_range(31), random_value());
        queue_request(pia_pkg::REQ_DUMP, $urandom_range(31), random_value());
        queue_request(pia_pkg::REQ_DELETE, Depth - 1, random_value());
    endfunction

    // one random step: mostly legal edits, some refused ones and noise
    function automatic void random_request();
        int r;
        int top;
        r   = $urandom_range(99);
        top = (plan_fill > 31) ? 31 : plan_fill;
        if (r < 4)
            queue_request(pia_pkg::REQ_CLEAR, $urandom_range(31), random_value());
        else if (r < 30)
            queue_request(pia_pkg::REQ_APPEND, $urandom_range(31), random_value());
        else if (r < 52)
            queue_request(pia_pkg::REQ_INSERT, $urandom_range(top, 0), random_value());
        else if (r < 74)
            queue_request(pia_pkg::REQ_DELETE,
                          plan_fill == 0 ? $urandom_range(31) : $urandom_range(plan_fill - 1, 0),
                          random_value());
        else if (r < 82)
            queue_request(pia_pkg::REQ_DUMP, $urandom_range(31), random_value());
        else if (r < 88)
            queue_request(pia_pkg::REQ_INSERT,
                          plan_fill >= 31 ? $urandom_range(31) : $urandom_range(31, plan_fill + 1),
                          random_value());
        else if (r < 94)
            queue_request(pia_pkg::REQ_DELETE,
                          plan_fill >= 32 ? $urandom_range(31) : $urandom_range(31, plan_fill),
                          random_value());
        else if (r < 97)
            queue_request(pia_pkg::ReqW'($urandom_range(REQ_CODE_TOP, pia_pkg::REQ_DUMP + 1)),
                          $urandom_range(31), random_value());
        else
            fill_to_full();
    endfunction

    // hold until every queued word went out and every result word came back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n_items, bit start_full);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = planned_items + n_items;
        if (start_full)
            fill_to_full();
        while (planned_items < target)
            random_request();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Driver: advance to the next word only after the current one is taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        request_t rq;
        logic     holding;
        holding = s_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                // predict from the payload that was on the ports at this edge
                rq.req = s_req_type;
                rq.pos = s_position;
                rq.val = s_value;
                apply_request(rq);
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    rq = pending_requests.pop_front();
                    s_valid    <= 1'b1;
                    s_req_type <= rq.req;
                    s_position <= rq.pos;
                    s_value    <= rq.val;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // stall the result channel at random, per the current phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result word with the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        result_t owed;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: status %0d data %0d count %0d last %0b",
                             m_status, m_data, m_count, m_last);
            end else begin
                owed = results_due.pop_front();
                if (m_status !== owed.status || m_data !== owed.data ||
                    m_count !== owed.count || m_last !== owed.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result mismatch: expected status %0d data %0d count %0d ",
                                  "last %0b, got status %0d data %0d count %0d last %0b"},
                                 owed.status, owed.data, owed.count, owed.last,
                                 m_status, m_data, m_count, m_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        while (!aresetn)
            @(posedge aclk);

        // directed part, no idling
        queue_request(pia_pkg::REQ_DUMP, 0, '0);               // dump of an empty array
        queue_request(pia_pkg::REQ_DELETE, 0, '0);             // delete on an empty array
        queue_request(pia_pkg::REQ_INSERT, 1, 32'sd5);         // insert past the end
        queue_request(pia_pkg::REQ_INSERT, 0, 32'sh7FFF_FFFF); // insert at count appends
        queue_request(pia_pkg::REQ_APPEND, 0, 32'sh8000_0000);
        queue_request(pia_pkg::REQ_APPEND, 31, '0);
        queue_request(pia_pkg::REQ_APPEND, 0, '1);
        queue_request(pia_pkg::REQ_INSERT, 1, 32'sh5555_5555); // shift the tail up
        queue_request(pia_pkg::REQ_INSERT, 5, 32'shAAAA_AAAA); // position equal to count
        queue_request(pia_pkg::REQ_INSERT, 31, '1);            // far past the end
        queue_request(pia_pkg::REQ_DUMP, 31, '1);
        queue_request(pia_pkg::REQ_DELETE, 0, '1);             // remove the head
        queue_request(pia_pkg::REQ_DELETE, 4, '0);             // remove the tail
        queue_request(pia_pkg::REQ_DELETE, 31, '0);            // at or above count
        queue_request(pia_pkg::REQ_DELETE, 2, '0);             // remove from the middle
        queue_request(pia_pkg::ReqW'(REQ_CODE_TOP - 2), 31, '1); // unused codes
        queue_request(pia_pkg::ReqW'(REQ_CODE_TOP - 1), 0, '0);
        queue_request(REQ_CODE_TOP, 31, '1);
        queue_request(pia_pkg::REQ_DUMP, 0, '0);
        queue_request(pia_pkg::REQ_CLEAR, 31, '1);
        queue_request(pia_pkg::REQ_DUMP, 0, '0);
        wait_drained();

        // random part: no idling, sender idle, receiver stalling, both
        run_phase(0, 0, 100, 1'b1);
        run_phase(64, 0, 100, 1'b0);
        run_phase(0, 64, 100, 1'b0);
        run_phase(9, 9, 100, 1'b0);

        // let any stray word surface before the verdict
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // end the run if the block hangs
    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
design/pia_pkg.sv
design/pia_ram.sv
design/positional_insert_delete_array.sv
dv/tb_positional_insert_delete_array.sv
